/* hw/rtl/radix_digit_display_scanner_macros.svh */
// Assertion macros for the radix digit display scanner.
`ifndef RADIX_DIGIT_DISPLAY_SCANNER_MACROS_SVH
`define RADIX_DIGIT_DISPLAY_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RDDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RDDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RDDS_ASSERT_NOW(lbl, ante, cons, msg)
`define RDDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/rdds_pkg.sv */
// Shared types and constants of the radix digit display scanner.
`default_nettype none

package rdds_pkg;

  localparam int DIGIT_COUNT  = 4;
  localparam int POS_W        = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int POS_XW       = POS_W + 2;

  localparam int VALUE_W      = 32;
  localparam int DIGIT_W      = 4;
  localparam int RADIX_W      = 5;
  localparam int CHUNK_W      = 8;
  localparam int CHUNKS       = VALUE_W / CHUNK_W;
  localparam int CHUNK_CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } q_item_t;

  // queue read side toward the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_rd_t;

endpackage

`default_nettype wire

/* hw/rtl/rdds_fifo.sv */
// Short queue between the front end and the back end.
`default_nettype none

module rdds_fifo import rdds_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t push_item_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output q_rd_t        rd_o
);

  q_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_o.valid  = (cnt_q != '0);
  assign rd_o.item   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdds_front.sv */
// Front end: takes input beats, classifies them as load or tick, feeds the queue.
`default_nettype none

module rdds_front import rdds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output q_item_t                 q_item_o
);

  logic    valid_q, valid_d;
  q_item_t item_q, item_d;
  logic    accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d      = 1'b1;
      item_d.op    = mode_i ? OP_TICK : OP_LOAD;
      item_d.value = value_i;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/rdds_back.sv */
// Back end: digit conversion by iterative division, digit store, scan and result register.
`default_nettype none

module rdds_back import rdds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [RADIX_W-1:0] radix_i,
  input  wire q_rd_t              q_rd_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              digit_position_o,
  output logic [DIGIT_W-1:0]      digit_value_o,
  output logic                    blank_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_W-1:0]     work_q, work_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [CHUNK_CNT_W-1:0] chunk_q, chunk_d;
  logic [POS_W-1:0]       k_q, k_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [DIGIT_W-1:0]     digit_store_q [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] blank_q, blank_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_pos_q;
  logic [DIGIT_W-1:0]     out_digit_q;
  logic                   out_blank_q;

  logic                   out_free;
  logic                   pop_tick;
  logic                   pop_load;
  logic                   digit_done;
  logic [DIGIT_W-1:0]     r_step;
  logic [RADIX_W-1:0]     t_step;
  logic [CHUNK_W-1:0]     q_byte;
  logic [POS_XW-1:0]      pos_x;
  logic                   lead;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = q_rd_i.valid && (state_q == ST_IDLE)
                       && ((q_rd_i.item.op == OP_LOAD) || out_free);
  assign pop_tick    = q_pop_o && (q_rd_i.item.op == OP_TICK);
  assign pop_load    = q_pop_o && (q_rd_i.item.op == OP_LOAD);
  assign digit_done  = (state_q == ST_DIV) && (chunk_q == CHUNK_CNT_W'(CHUNKS - 1));
  assign pos_x       = POS_XW'(pos_q);

  assign out_valid_o      = out_valid_q;
  assign digit_position_o = out_pos_q;
  assign digit_value_o    = out_digit_q;
  assign blank_o          = out_blank_q;

  // restoring division, one byte of the dividend per cycle
  always_comb begin
    r_step = rem_q;
    t_step = '0;
    q_byte = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      t_step = {r_step, work_q[VALUE_W-1-i]};
      if (t_step >= radix_i) begin
        q_byte[CHUNK_W-1-i] = 1'b1;
        t_step              = t_step - radix_i;
      end
      r_step = t_step[DIGIT_W-1:0];
    end
  end

  // leading-zero blanking, position 0 never blank
  always_comb begin
    lead    = 1'b1;
    blank_d = '0;
    for (int k = DIGIT_COUNT - 1; k > 0; k--) begin
      lead       = lead && (digit_store_q[k] == '0);
      blank_d[k] = lead;
    end
  end

  always_comb begin
    state_d = state_q;
    work_d  = work_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_load) begin
          work_d  = q_rd_i.item.value;
          rem_d   = '0;
          chunk_d = '0;
          k_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        work_d = {work_q[VALUE_W-CHUNK_W-1:0], q_byte};
        rem_d  = r_step;
        if (digit_done) begin
          rem_d   = '0;
          chunk_d = '0;
          if (k_q == POS_W'(DIGIT_COUNT - 1)) begin
            state_d = ST_FIN;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    if (pop_tick) begin
      out_valid_d = 1'b1;
      pos_d       = (pos_q == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      blank_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_FIN) begin
        blank_q <= blank_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (digit_done) begin
      digit_store_q[k_q] <= r_step;
    end
    if (pop_tick) begin
      out_pos_q   <= pos_x[1:0];
      out_blank_q <= blank_q[pos_q];
      out_digit_q <= blank_q[pos_q] ? '0 : digit_store_q[pos_q];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/radix_digit_display_scanner.sv */
// Top level of the radix digit display scanner: base register, front end, queue, back end.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   mode_i, value_i
//   out      output     out_valid_o / out_stall_i digit_position_o, digit_value_o, blank_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (base)
//
// A tick is popped only while the result register is free; its beat sits in the result register next cycle.
// A load runs the byte-wide divider over the whole value once per digit, between the pop
// and the blanking state; the back end pops nothing else until it is back in idle.
// Front register and queue are registered and hide up to three beats of stall.
// Reset: base 10, all positions blank, scan at position 0.
// A held result stalls only ticks; queued beats wait, the input keeps taking beats until full.
`default_nettype none

`include "radix_digit_display_scanner_macros.svh"

module radix_digit_display_scanner import rdds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              digit_position_o,
  output logic [DIGIT_W-1:0]      digit_value_o,
  output logic                    blank_o,
  input  wire logic               cfg_we_i,
  input  wire logic [RADIX_W-1:0] cfg_wdata_i
);

  logic [RADIX_W-1:0] radix_q;
  logic               cfg_ok;
  logic               q_push;
  q_item_t            q_item;
  logic               q_full;
  logic               q_pop;
  q_rd_t              q_rd;

  assign cfg_ok = cfg_we_i && (cfg_wdata_i >= RADIX_MIN) && (cfg_wdata_i <= RADIX_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_ok) begin
      radix_q <= cfg_wdata_i;
    end
  end

  rdds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  rdds_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .rd_o        (q_rd)
  );

  rdds_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .radix_i          (radix_q),
    .q_rd_i           (q_rd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_position_o (digit_position_o),
    .digit_value_o    (digit_value_o),
    .blank_o          (blank_o)
  );

  `RDDS_ASSERT_NOW(a_radix_range, 1'b1, (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX), "base out of range")
  `RDDS_ASSERT_NEXT(a_bad_cfg_kept, cfg_we_i && !cfg_ok, $stable(radix_q), "bad base write took effect")
  `RDDS_ASSERT_NOW(a_pop_nonempty, q_pop, q_rd.valid, "pop from empty queue")
  `RDDS_ASSERT_NOW(a_result_from_tick, $rose(out_valid_o), $past(q_pop && (q_rd.item.op == OP_TICK)), "result without tick")

endmodule

`default_nettype wire
